// File: rtl/core/csikd_pkg.sv
`timescale 1ns / 1ps
package csikd_pkg;

   // byte codes of the sequence body and final letter
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] FINAL_U     = 8'h75;
   localparam logic [7:0] FINAL_TILDE = 8'h7E;

   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] CP_BACKSPACE = 21'd8;
   localparam logic [20:0] CP_TAB       = 21'd9;
   localparam logic [20:0] CP_RETURN    = 21'd13;
   localparam logic [20:0] CP_ESCAPE    = 21'd27;
   localparam logic [20:0] CP_SPACE     = 21'd32;
   localparam logic [20:0] CP_DELETE    = 21'd127;
   localparam logic [20:0] CP_LOWER_A   = 21'd97;
   localparam logic [20:0] CP_LOWER_Z   = 21'd122;
   localparam logic [20:0] CP_CASE_GAP  = 21'd32;

   localparam logic [2:0] KIND_PLAIN     = 3'd0;
   localparam logic [2:0] KIND_BACKSPACE = 3'd1;
   localparam logic [2:0] KIND_TAB       = 3'd2;
   localparam logic [2:0] KIND_RETURN    = 3'd3;
   localparam logic [2:0] KIND_ESCAPE    = 3'd4;

   typedef struct packed {
      logic [2:0][20:0] params;
      logic [1:0]       count;
      logic [20:0]      acc;
      logic             digit_seen;
      logic             in_sub;
      logic             err;
      logic             nonempty;
   } csikd_state_type;

   typedef struct packed {
      logic        shift_held;
      logic        alt_held;
      logic        ctrl_held;
      logic [20:0] code_point;
      logic [2:0]  key_kind;
      logic        ok;
   } csikd_result_type;

endpackage

// File: rtl/core/csi_key_sequence_decoder.sv
`timescale 1ns / 1ps
// Decodes the body of a terminal CSI key report, one byte per word on req_tdata, with
// req_tlast set on the final letter ('u' or '~'). A body word is taken every clock cycle
// unless a final word waits in the input register; the parameter accumulator and parser
// flags form the only feedback loop. Each final word yields one result word, raised on
// rsp_tvalid when it moves from the input register into rsp_ff; body words yield nothing.
// A final word waits in the input register only while an earlier result is still held,
// so with rsp_tready high words follow back to back. A rejected sequence gives a result
// with ok low and all other fields zero. The parser state clears after every final word.
module csi_key_sequence_decoder
   import csikd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // body_byte
   input  logic        req_tlast,   // is_final
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // ok, key_kind[2:0], code_point[20:0], ctrl_held,
                                    // alt_held, shift_held, zero fill
);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_final_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   csikd_result_type rsp_ff;
   csikd_result_type result;
   csikd_state_type  state;
   logic             rsp_free;
   logic             advance;
   logic             take;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // body words never wait on the result side
   assign advance    = in_valid_ff && (!in_final_ff || rsp_free);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_final_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   csikd_body u_body (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .body_byte (in_byte_ff),
      .is_final  (in_final_ff),
      .state     (state)
   );

   csikd_finish u_finish (
      .state      (state),
      .final_byte (in_byte_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff  <= req_tdata;
         in_final_ff <= req_tlast;
      end
      if (advance && in_final_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff};

`ifndef SYNTH
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_final_ff))
      else $error("result word without a final input word");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |-> rsp_ff == '0)
      else $error("rejected result carries non-zero fields");
   a_plain_no_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ok && rsp_ff.key_kind == KIND_PLAIN |-> !rsp_ff.shift_held)
      else $error("shift kept on a plain key");
`endif

endmodule

// File: rtl/core/csikd_body.sv
`timescale 1ns / 1ps
module csikd_body
   import csikd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      body_byte,
   input  logic            is_final,
   output csikd_state_type state
);

   csikd_state_type state_ff;
   csikd_state_type state_in;
   logic [23:0]     acc_wide;
   logic [23:0]     acc_next;

   assign acc_wide = {3'b000, state_ff.acc};
   // times ten as two shifts
   assign acc_next = (acc_wide << 3) + (acc_wide << 1) + {20'd0, body_byte[3:0]};

   always_comb begin
      state_in = state_ff;
      if (step) begin
         if (is_final) begin
            state_in = '0;
         end else begin
            state_in.nonempty = 1'b1;
            if (!state_ff.err) begin
               priority if (body_byte == CHAR_SEMI) begin
                  if (!state_ff.digit_seen || state_ff.count == 2'd3) begin
                     state_in.err = 1'b1;
                  end else begin
                     if (state_ff.count == 2'd0) begin
                        state_in.params[0] = state_ff.acc;
                     end else if (state_ff.count == 2'd1) begin
                        state_in.params[1] = state_ff.acc;
                     end else begin
                        state_in.params[2] = state_ff.acc;
                     end
                     state_in.count      = state_ff.count + 2'd1;
                     state_in.acc        = '0;
                     state_in.digit_seen = 1'b0;
                     state_in.in_sub     = 1'b0;
                  end
               end else if (body_byte == CHAR_COLON) begin
                  state_in.in_sub = 1'b1;
               end else if (body_byte < CHAR_ZERO || body_byte > CHAR_NINE) begin
                  state_in.err = 1'b1;
               end else begin
                  // digits of a sub-parameter are skipped
                  if (!state_ff.in_sub) begin
                     state_in.digit_seen = 1'b1;
                     if (acc_next > {3'b000, CP_MAX}) begin
                        state_in.err = 1'b1;
                        state_in.acc = '0;
                     end else begin
                        state_in.acc = acc_next[20:0];
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

`ifndef SYNTH
   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      step && is_final |=> state_ff == '0)
      else $error("parser state not cleared after final word");
   a_acc_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.acc <= CP_MAX)
      else $error("accumulator above code point limit");
`endif

endmodule

// File: rtl/core/csikd_finish.sv
`timescale 1ns / 1ps
module csikd_finish
   import csikd_pkg::*;
(
   input  csikd_state_type  state,
   input  logic [7:0]       final_byte,
   output csikd_result_type result
);

   logic        good;
   logic [20:0] cp;
   logic [20:0] mods;
   logic [2:0]  bits;
   logic [2:0]  kind;
   logic [20:0] cp_adj;

   always_comb begin
      good = !state.err && state.nonempty && state.digit_seen && state.count != 2'd3 &&
             (final_byte == FINAL_U || final_byte == FINAL_TILDE);
      // the accumulator is the last parameter on the final word
      if (final_byte == FINAL_U) begin
         good = good && (state.count == 2'd0 || state.count == 2'd1);
         cp   = (state.count == 2'd0) ? state.acc : state.params[0];
         mods = (state.count == 2'd1) ? state.acc : 21'd1;
      end else begin
         good = good && state.count == 2'd2 && state.params[0] == CP_ESCAPE;
         mods = state.params[1];
         cp   = state.acc;
      end
      good = good && cp <= CP_MAX && mods != 21'd0;
      bits = mods[2:0] - 3'd1;

      priority if (cp == CP_BACKSPACE || cp == CP_DELETE) begin
         kind = KIND_BACKSPACE;
      end else if (cp == CP_TAB) begin
         kind = KIND_TAB;
      end else if (cp == CP_RETURN) begin
         kind = KIND_RETURN;
      end else if (cp == CP_ESCAPE) begin
         kind = KIND_ESCAPE;
      end else begin
         kind = KIND_PLAIN;
         if (cp < CP_SPACE) good = 1'b0;
      end

      // shift upper-cases ascii letters
      cp_adj = (bits[0] && cp >= CP_LOWER_A && cp <= CP_LOWER_Z) ? cp - CP_CASE_GAP : cp;

      result = '0;
      if (good) begin
         result.ok         = 1'b1;
         result.key_kind   = kind;
         result.code_point = (kind == KIND_PLAIN) ? cp_adj : 21'd0;
         result.ctrl_held  = bits[2];
         result.alt_held   = bits[1];
         result.shift_held = bits[0] && kind != KIND_PLAIN;
      end
   end

endmodule
